// File: hdl/stkcalc_pkg.sv
package stkcalc_pkg;

  // Input command codes
  typedef enum logic [2:0] {
    CMD_PUSH     = 3'd0,
    CMD_POP      = 3'd1,
    CMD_ADD      = 3'd2,
    CMD_SUB      = 3'd3,
    CMD_MUL      = 3'd4,
    CMD_DIV      = 3'd5,
    CMD_PEEK_TOP = 3'd6,
    CMD_PEEK_BOT = 3'd7
  } cmd_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FEW     = 3'd2,
    ST_INDEX   = 3'd3,
    ST_DIVZERO = 3'd4,
    ST_FULL    = 3'd5
  } status_e;

  // Command class after decode
  typedef enum logic [2:0] {
    K_PUSH     = 3'd0,
    K_POP      = 3'd1,
    K_BIN      = 3'd2,
    K_PEEK_TOP = 3'd3,
    K_PEEK_BOT = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_e;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] operand_value;
    logic [7:0]         position;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         status;
    logic [8:0]         depth;
  } out_item_t;

  // Decoded command as it travels through the queue
  typedef struct packed {
    kind_e       kind;
    alu_e        alu;
    logic [31:0] value;
    logic [7:0]  position;
  } op_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QAW       = $clog2(QDEPTH);
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CW    = $clog2(DIV_STEPS);

endpackage

// File: hdl/stkcalc_front.sv
module stkcalc_front
  import stkcalc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  output logic     push_valid_o,
  output op_t      push_data_o,
  input  logic     q_full_i
);

  logic hold_valid_q, hold_valid_d;
  op_t  hold_q, dec;
  logic accept, handoff;

  always_comb begin
    dec.value    = in_data_i.operand_value;
    dec.position = in_data_i.position;
    dec.alu      = ALU_ADD;
    case (cmd_e'(in_data_i.command))
      CMD_PUSH:     dec.kind = K_PUSH;
      CMD_POP:      dec.kind = K_POP;
      CMD_ADD: begin
        dec.kind = K_BIN;
        dec.alu  = ALU_ADD;
      end
      CMD_SUB: begin
        dec.kind = K_BIN;
        dec.alu  = ALU_SUB;
      end
      CMD_MUL: begin
        dec.kind = K_BIN;
        dec.alu  = ALU_MUL;
      end
      CMD_DIV: begin
        dec.kind = K_BIN;
        dec.alu  = ALU_DIV;
      end
      CMD_PEEK_TOP: dec.kind = K_PEEK_TOP;
      CMD_PEEK_BOT: dec.kind = K_PEEK_BOT;
      default:      dec.kind = K_PEEK_BOT;
    endcase
  end

  assign in_stall_o   = hold_valid_q & q_full_i;
  assign accept       = in_valid_i & ~in_stall_o;
  assign handoff      = hold_valid_q & ~q_full_i;
  assign push_valid_o = hold_valid_q;
  assign push_data_o  = hold_q;

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (accept) begin
      hold_valid_d = 1'b1;
    end else if (handoff) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q <= dec;
    end
  end

endmodule

// File: hdl/stkcalc_queue.sv
module stkcalc_queue
  import stkcalc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  op_t  push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output op_t  data_o
);

  op_t            slots_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QAW:0]   fill_q, fill_d;
  logic           do_push, do_pop;

  assign full_o  = fill_q == (QAW+1)'(QDEPTH);
  assign valid_o = fill_q != '0;
  assign data_o  = slots_q[rd_ptr_q];
  assign do_push = push_valid_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + (QAW+1)'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hdl/stkcalc_divider.sv
module stkcalc_divider
  import stkcalc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              busy_q, done_q, neg_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [31:0]       rem_q, quo_q, dmag_q;
  logic [31:0]       nmag, dmag;
  logic [32:0]       trial, diff;

  // restoring divide on magnitudes, one quotient bit per cycle
  assign nmag  = req_i.num[31] ? -req_i.num : req_i.num;
  assign dmag  = req_i.den[31] ? -req_i.den : req_i.den;
  assign trial = {rem_q, quo_q[31]};
  assign diff  = trial - {1'b0, dmag_q};

  // floor: mixed signs round toward minus infinity when inexact
  assign rsp_o.done = done_q;
  assign rsp_o.quot = !neg_q ? quo_q : ((rem_q != '0) ? ~quo_q : -quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CW'(DIV_STEPS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - DIV_CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      quo_q  <= nmag;
      dmag_q <= dmag;
      neg_q  <= req_i.num[31] ^ req_i.den[31];
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_q <= diff[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

endmodule

// File: hdl/stkcalc_back.sv
module stkcalc_back
  import stkcalc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  output logic      q_pop_o,
  input  op_t       q_data_i,
  output div_req_t  div_req_o,
  input  div_rsp_t  div_rsp_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RDW   = 6'b000010,
    S_TOPW  = 6'b000100,
    S_NEXTW = 6'b001000,
    S_ALU   = 6'b010000,
    S_DIV   = 6'b100000
  } state_e;

  state_e      state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  op_t         cur_q, cur_d;
  logic [31:0] top_q, top_d, next_q, next_d;
  logic        out_valid_q;
  out_item_t   out_q, out_d;

  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rdata_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata;

  logic        fin, out_free, full, bad_idx;
  logic [31:0] fin_res;
  status_e     fin_st;
  logic [31:0] cnt32, cnt32_d, pos32, top_addr32, last32, second32;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign full     = count_q == CW'(STACK_DEPTH);
  assign cnt32    = 32'(count_q);
  assign pos32    = 32'(q_data_i.position);
  assign bad_idx  = pos32 >= cnt32;
  assign last32     = cnt32 - 32'd1;
  assign second32   = cnt32 - 32'd2;
  assign top_addr32 = last32 - pos32;
  assign cnt32_d    = 32'(count_d);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    cur_d     = cur_q;
    top_d     = top_q;
    next_d    = next_q;
    q_pop_o   = 1'b0;
    we        = 1'b0;
    waddr     = second32[AW-1:0];
    wdata     = '0;
    raddr     = last32[AW-1:0];
    fin       = 1'b0;
    fin_res   = '0;
    fin_st    = ST_OK;
    div_req_o = '0;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          cur_d   = q_data_i;
          case (q_data_i.kind)
            K_PUSH: begin
              fin = 1'b1;
              if (full) begin
                fin_st = ST_FULL;
              end else begin
                we      = 1'b1;
                waddr   = count_q[AW-1:0];
                wdata   = q_data_i.value;
                count_d = count_q + CW'(1);
              end
            end
            K_POP: begin
              if (count_q == '0) begin
                fin    = 1'b1;
                fin_st = ST_EMPTY;
              end else begin
                state_d = S_RDW;
              end
            end
            K_BIN: begin
              if (count_q < CW'(2)) begin
                fin    = 1'b1;
                fin_st = ST_FEW;
              end else begin
                state_d = S_TOPW;
              end
            end
            K_PEEK_TOP: begin
              raddr = top_addr32[AW-1:0];
              if (bad_idx) begin
                fin    = 1'b1;
                fin_st = ST_INDEX;
              end else begin
                state_d = S_RDW;
              end
            end
            K_PEEK_BOT: begin
              raddr = pos32[AW-1:0];
              if (bad_idx) begin
                fin    = 1'b1;
                fin_st = ST_INDEX;
              end else begin
                state_d = S_RDW;
              end
            end
            default: begin
              fin    = 1'b1;
              fin_st = ST_INDEX;
            end
          endcase
        end
      end
      S_RDW: begin
        fin     = 1'b1;
        fin_res = rdata_q;
        if (cur_q.kind == K_POP) begin
          count_d = count_q - CW'(1);
        end
        state_d = S_IDLE;
      end
      S_TOPW: begin
        top_d   = rdata_q;
        raddr   = second32[AW-1:0];
        state_d = S_NEXTW;
      end
      S_NEXTW: begin
        next_d = rdata_q;
        if (cur_q.alu == ALU_DIV) begin
          if (top_q == '0) begin
            // both operands are consumed, nothing pushed
            count_d = count_q - CW'(2);
            fin     = 1'b1;
            fin_st  = ST_DIVZERO;
            state_d = S_IDLE;
          end else begin
            div_req_o.start = 1'b1;
            div_req_o.num   = rdata_q;
            div_req_o.den   = top_q;
            state_d         = S_DIV;
          end
        end else begin
          state_d = S_ALU;
        end
      end
      S_ALU: begin
        case (cur_q.alu)
          ALU_ADD: fin_res = next_q + top_q;
          ALU_SUB: fin_res = next_q - top_q;
          ALU_MUL: fin_res = next_q * top_q;
          default: fin_res = next_q + top_q;
        endcase
        we      = 1'b1;
        wdata   = fin_res;
        count_d = count_q - CW'(1);
        fin     = 1'b1;
        state_d = S_IDLE;
      end
      S_DIV: begin
        if (div_rsp_i.done) begin
          fin_res = div_rsp_i.quot;
          we      = 1'b1;
          wdata   = div_rsp_i.quot;
          count_d = count_q - CW'(1);
          fin     = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_d.result_value = fin_res;
    out_d.status       = fin_st;
    out_d.depth        = cnt32_d[8:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    top_q  <= top_d;
    next_q <= next_d;
    if (fin) begin
      out_q <= out_d;
    end
  end

  // stack storage: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hdl/stack_calculator.sv
// RPN stack calculator. Each transfer on the input carries one command (push, pop, add,
// subtract, multiply, floored divide, peek from top, peek from bottom) and yields exactly
// one result transfer with the value, a status code and the stack depth after the command.
// A front stage decodes commands into a two-entry queue; the back end executes them
// against a stack memory of STACK_DEPTH words (one write port, one registered read port)
// whose contents are not cleared at reset (only written entries are ever read). Push and
// the empty, too-few, bad-index and full cases finish in the idle state; pop and peek
// pass a read-wait state, divide by zero the top and next read states, add/sub/multiply
// those and an ALU state, and divide those and a wait on the radix-2 divider, retiring
// one quotient bit per cycle over 32 bits. A stalled result holds off the executor.
module stack_calculator
  import stkcalc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic     push_valid, q_full, q_valid, q_pop;
  op_t      push_data, q_data;
  div_req_t div_req;
  div_rsp_t div_rsp;

  stkcalc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .q_full_i     (q_full)
  );

  stkcalc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .data_o       (q_data)
  );

  stkcalc_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  stkcalc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_data_i    (q_data),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: dv/tb_stack_calculator.sv
module tb_stack_calculator;
  import stkcalc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned NUM_ITEMS   = 1700;
  // sender runs back to back over this window, receiver never stalls in it
  localparam int unsigned QUIET_LO    = 600;
  localparam int unsigned QUIET_HI    = 700;
  localparam int unsigned PAUSE_AT    = 1000;
  localparam int unsigned HOLD_AT     = 300;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIX
  } traffic_e;

  class calc_scoreboard;
    logic [31:0] stack_mem [STACK_DEPTH];
    int unsigned entries;
    out_item_t   pending_results [$];
    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned cmd_hits [8];
    int unsigned status_hits [6];

    function new();
      entries         = 0;
      mismatches      = 0;
      results_checked = 0;
      foreach (cmd_hits[i]) cmd_hits[i] = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function int unsigned depth();
      return entries;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function out_item_t predict_result(in_item_t it);
      logic [31:0]   top;
      logic [31:0]   nxt;
      logic [31:0]   res;
      status_e       st;
      longint signed n;
      longint signed d;
      longint signed q;
      out_item_t     r;
      res = '0;
      st  = ST_OK;
      case (cmd_e'(it.command))
        CMD_PUSH: begin
          if (entries >= STACK_DEPTH) begin
            st = ST_FULL;
          end else begin
            stack_mem[entries] = it.operand_value;
            entries++;
          end
        end
        CMD_POP: begin
          if (entries == 0) begin
            st = ST_EMPTY;
          end else begin
            entries--;
            res = stack_mem[entries];
          end
        end
        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
          if (entries < 2) begin
            st = ST_FEW;
          end else begin
            top = stack_mem[entries-1];
            nxt = stack_mem[entries-2];
            entries -= 2;
            case (cmd_e'(it.command))
              CMD_ADD: res = nxt + top;
              CMD_SUB: res = nxt - top;
              CMD_MUL: res = nxt * top;
              default: begin
                if (top == '0) begin
                  st = ST_DIVZERO;
                end else begin
                  n = $signed(nxt);
                  d = $signed(top);
                  q = n / d;
                  // round toward minus infinity, exact quotients untouched
                  if ((n % d) != 0 && ((n < 0) != (d < 0))) q = q - 1;
                  res = q[31:0];
                end
              end
            endcase
            if (st == ST_OK) begin
              stack_mem[entries] = res;
              entries++;
            end
          end
        end
        CMD_PEEK_TOP: begin
          if (it.position >= entries) st = ST_INDEX;
          else res = stack_mem[entries - 1 - it.position];
        end
        default: begin
          if (it.position >= entries) st = ST_INDEX;
          else res = stack_mem[it.position];
        end
      endcase
      if (st != ST_OK) res = '0;
      r.result_value = res;
      r.status       = st;
      r.depth        = entries[8:0];
      return r;
    endfunction

    function void note_command(in_item_t it);
      cmd_hits[it.command]++;
      pending_results.push_back(predict_result(it));
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] mismatch on result %0d, %s: expected 0x%08h, got 0x%08h",
                 $time, results_checked, field, want, got);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_checked++;
      if (pending_results.size() == 0) begin
        report("transfer with nothing outstanding", '0, got.result_value);
        return;
      end
      want = pending_results.pop_front();
      status_hits[want.status]++;
      if (got.result_value !== want.result_value)
        report("result_value", want.result_value, got.result_value);
      if (got.status !== want.status)
        report("status", 32'(want.status), 32'(got.status));
      if (got.depth !== want.depth)
        report("depth", 32'(want.depth), 32'(got.depth));
    endfunction

    function void close_out();
      if (pending_results.size() != 0) begin
        mismatches++;
        $display("%0d expected results never came out", pending_results.size());
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  calc_scoreboard sb = new();
  int unsigned    items_sent = 0;

  stack_calculator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d results outstanding", sb.pending());
    $display("FAILURE");
    $finish;
  end

  function automatic in_item_t make_item(cmd_e c, logic [31:0] v, logic [7:0] p);
    in_item_t it;
    it.command       = c;
    it.operand_value = v;
    it.position      = p;
    return it;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return 32'h0000_0000;
      4, 5:    return $urandom_range(0, 20) - 10;
      default: return $urandom();
    endcase
  endfunction

  function automatic cmd_e pick_command(traffic_e mode);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (r < 85) return CMD_PUSH;
        return cmd_e'($urandom_range(1, 7));
      end
      MODE_DRAIN: begin
        if (r < 15) return CMD_PUSH;
        if (r < 40) return CMD_POP;
        if (r < 85) return cmd_e'($urandom_range(2, 5));
        return cmd_e'($urandom_range(6, 7));
      end
      default: begin
        if (r < 35) return CMD_PUSH;
        return cmd_e'($urandom_range(1, 7));
      end
    endcase
  endfunction

  function automatic in_item_t random_item(traffic_e mode);
    cmd_e        c;
    logic [7:0]  p;
    int unsigned d;
    c = pick_command(mode);
    d = sb.depth();
    // peeks mostly land inside the stack, the rest probe any index
    if ((c == CMD_PEEK_TOP || c == CMD_PEEK_BOT) && d > 0 && $urandom_range(0, 4) != 0)
      p = 8'($urandom_range(0, d - 1));
    else
      p = 8'($urandom_range(0, 255));
    return make_item(c, pick_value(), p);
  endfunction

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = (items_sent >= QUIET_LO && items_sent < QUIET_HI) ? 0 : $urandom_range(0, 8);
    if (items_sent == PAUSE_AT) gap = gap + 1;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      // let the block drain completely once
      if (items_sent == PAUSE_AT)
        while (sb.pending() > 0) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_command(it);
    items_sent++;
  endtask

  task automatic send_cmd(input cmd_e c, input logic [31:0] v, input logic [7:0] p);
    send_item(make_item(c, v, p));
  endtask

  task automatic run_directed();
    send_cmd(CMD_POP,      $urandom(), 8'($urandom_range(0, 255)));
    send_cmd(CMD_ADD,      $urandom(), 8'($urandom_range(0, 255)));
    send_cmd(CMD_PEEK_TOP, $urandom(), 8'd0);
    send_cmd(CMD_PEEK_BOT, $urandom(), 8'd255);
    send_cmd(CMD_PUSH,     32'h7fff_ffff, 8'd0);
    send_cmd(CMD_DIV,      $urandom(), 8'd0);          // one operand only
    send_cmd(CMD_PUSH,     32'h8000_0000, 8'd255);
    send_cmd(CMD_ADD,      $urandom(), 8'd0);          // -1
    send_cmd(CMD_PUSH,     32'h8000_0000, 8'd0);
    send_cmd(CMD_PUSH,     32'hffff_ffff, 8'd0);
    send_cmd(CMD_DIV,      $urandom(), 8'd0);          // min / -1 wraps
    send_cmd(CMD_PUSH,     32'h0000_0000, 8'd0);
    send_cmd(CMD_DIV,      $urandom(), 8'd0);          // by zero, both consumed
    send_cmd(CMD_PUSH,     -32'sd7, 8'd0);
    send_cmd(CMD_PUSH,     32'd2, 8'd0);
    send_cmd(CMD_DIV,      $urandom(), 8'd0);          // inexact, mixed signs
    send_cmd(CMD_PUSH,     32'd3, 8'd0);
    send_cmd(CMD_MUL,      $urandom(), 8'd0);
    send_cmd(CMD_PUSH,     32'd4, 8'd0);
    send_cmd(CMD_DIV,      $urandom(), 8'd0);          // exact, mixed signs
    send_cmd(CMD_SUB,      $urandom(), 8'd0);
    send_cmd(CMD_PEEK_TOP, $urandom(), 8'd0);
    send_cmd(CMD_PEEK_BOT, $urandom(), 8'd0);
    send_cmd(CMD_PEEK_TOP, $urandom(), 8'd1);          // past the bottom
    send_cmd(CMD_POP,      $urandom(), 8'd0);
  endtask

  task automatic fill_stack();
    while (sb.depth() < STACK_DEPTH) send_item(random_item(MODE_FILL));
    send_cmd(CMD_PUSH,     pick_value(), 8'($urandom_range(0, 255)));
    send_cmd(CMD_PEEK_TOP, $urandom(), 8'd255);
    send_cmd(CMD_PEEK_BOT, $urandom(), 8'd255);
    send_cmd(CMD_PUSH,     pick_value(), 8'($urandom_range(0, 255)));
  endtask

  // result side
  initial begin
    int unsigned results_seen;
    int unsigned hold;
    results_seen = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (results_seen == HOLD_AT)
        hold = HOLD_CYCLES;
      else if (results_seen >= QUIET_LO && results_seen < QUIET_HI)
        hold = 0;
      else
        hold = $urandom_range(0, 8);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(out_data);
      results_seen++;
    end
  end

  // command side and end of run
  initial begin
    int unsigned seg;
    int unsigned len;
    traffic_e    mode;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    seg = 0;
    while (items_sent < NUM_ITEMS) begin
      if (seg % 10 == 3) begin
        fill_stack();
      end else begin
        mode = traffic_e'($urandom_range(0, 2));
        len  = $urandom_range(20, 80);
        repeat (len) send_item(random_item(mode));
      end
      seg++;
    end
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    sb.close_out();
    $display("Covered %0d commands: push %0d pop %0d add %0d sub %0d mul %0d div %0d",
             items_sent, sb.cmd_hits[CMD_PUSH], sb.cmd_hits[CMD_POP], sb.cmd_hits[CMD_ADD],
             sb.cmd_hits[CMD_SUB], sb.cmd_hits[CMD_MUL], sb.cmd_hits[CMD_DIV]);
    $display("Peeks top/bottom %0d/%0d", sb.cmd_hits[CMD_PEEK_TOP],
             sb.cmd_hits[CMD_PEEK_BOT]);
    $display("Status mix: ok %0d empty %0d few %0d index %0d div0 %0d full %0d, %0d mismatches",
             sb.status_hits[ST_OK], sb.status_hits[ST_EMPTY], sb.status_hits[ST_FEW],
             sb.status_hits[ST_INDEX], sb.status_hits[ST_DIVZERO], sb.status_hits[ST_FULL],
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
